[hdl/alp_pkg.sv]
// Shared constants, codes and record type of the account ledger.
package alp_pkg;

	localparam int MAX_ACCOUNTS = 256;
	localparam int IDX_W        = $clog2(MAX_ACCOUNTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int KEY_BYTES    = 8;
	localparam int KEY_W        = 64;
	localparam int VAL_W        = 63;
	localparam int PNL_W        = 64;
	localparam int VER_W        = 32;
	localparam int AMT_W        = 31;
	localparam int OP_W         = 4;
	localparam int ST_W         = 3;
	localparam int LIMIT_W      = 9;
	localparam int PROD_W       = 2 * AMT_W;

	localparam int IN_TDATA_W   = 200;
	localparam int OUT_TDATA_W  = 424;

	// Operation codes
	localparam logic [OP_W-1:0] OP_OPEN     = 4'd0;
	localparam logic [OP_W-1:0] OP_DEPOSIT  = 4'd1;
	localparam logic [OP_W-1:0] OP_WITHDRAW = 4'd2;
	localparam logic [OP_W-1:0] OP_RESERVE  = 4'd3;
	localparam logic [OP_W-1:0] OP_RELEASE  = 4'd4;
	localparam logic [OP_W-1:0] OP_SETTLE   = 4'd5;
	localparam logic [OP_W-1:0] OP_BUY      = 4'd6;
	localparam logic [OP_W-1:0] OP_SELL_RES = 4'd7;
	localparam logic [OP_W-1:0] OP_SELL_REL = 4'd8;
	localparam logic [OP_W-1:0] OP_SELL     = 4'd9;
	localparam logic [OP_W-1:0] OP_SEED     = 4'd10;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [ST_W-1:0] ST_QTY     = 3'd2;
	localparam logic [ST_W-1:0] ST_PRICE   = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTOPEN = 3'd4;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd5;
	localparam logic [ST_W-1:0] ST_INDEX   = 3'd6;

	typedef struct packed {
		logic [VER_W-1:0] version;
		logic [PNL_W-1:0] realized;
		logic [VAL_W-1:0] rshares;
		logic [VAL_W-1:0] cost;
		logic [VAL_W-1:0] shares;
		logic [VAL_W-1:0] rcash;
		logic [VAL_W-1:0] cash;
	} alp_rec_t;

	localparam int REC_W = $bits(alp_rec_t);

endpackage

[hdl/alp_ram.sv]
// Generic single-clock RAM, one write port, one registered read port.
module alp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/alp_muldiv.sv]
// Exact floor(a * m / d): two partial products, then a bit-serial restoring divide.
module alp_muldiv
	import alp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] a,
	input  logic [AMT_W-1:0] m,
	input  logic [VAL_W-1:0] d,
	output logic             done,
	output logic [VAL_W-1:0] quot
);

	localparam int NUM_W = VAL_W + AMT_W;
	localparam int LO_W  = 32;
	localparam int HI_W  = VAL_W - LO_W;
	localparam int DC_W  = $clog2(NUM_W + 1);

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_MLO  = 3'd1;
	localparam logic [2:0] P_MHI  = 3'd2;
	localparam logic [2:0] P_SUM  = 3'd3;
	localparam logic [2:0] P_DIV  = 3'd4;

	logic [2:0]            phase_q;
	logic [VAL_W-1:0]      a_q;
	logic [AMT_W-1:0]      m_q;
	logic [VAL_W-1:0]      d_q;
	logic [LO_W+AMT_W-1:0] plo_q;
	logic [HI_W+AMT_W-1:0] phi_q;
	logic [NUM_W-1:0]      num_q;
	logic [VAL_W-1:0]      rem_q;
	logic [DC_W-1:0]       cnt_q;
	logic                  done_q;
	logic [VAL_W:0]        rem_sh;
	logic                  take;

	// One restoring step
	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		take   = rem_sh >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						a_q     <= a;
						m_q     <= m;
						d_q     <= d;
						phase_q <= P_MLO;
					end
				end
				P_MLO: begin
					plo_q   <= a_q[LO_W-1:0] * m_q;
					phase_q <= P_MHI;
				end
				P_MHI: begin
					phi_q   <= a_q[VAL_W-1:LO_W] * m_q;
					phase_q <= P_SUM;
				end
				P_SUM: begin
					num_q   <= {phi_q, {LO_W{1'b0}}} + {{(NUM_W-LO_W-AMT_W){1'b0}}, plo_q};
					rem_q   <= '0;
					cnt_q   <= DC_W'(NUM_W);
					phase_q <= P_DIV;
				end
				P_DIV: begin
					// shift one dividend bit in, one quotient bit out
					rem_q <= take ? VAL_W'(rem_sh - {1'b0, d_q}) : rem_sh[VAL_W-1:0];
					num_q <= {num_q[NUM_W-2:0], take};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == DC_W'(1)) begin
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quot = num_q[VAL_W-1:0];

endmodule

[hdl/account_balance_position_ledger.sv]
// Account ledger top level: slot table in RAM, read-modify-write sequencer.
// Each item runs the read, load, execute and output states; open first scans
// the key table over up to n slots, n = min(account_limit, 256); a partial
// sell fill adds the two partial products and the 94-step restoring divide.
// One item at a time; the next beat is taken as soon as the result is in
// the output register. Reset clears all in-use flags at once, so every
// slot reads as zero until opened; account_limit resets to 256.
module account_balance_position_ledger
	import alp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// account_key, account_index, amount, price, seed_realized, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic [OP_W-1:0]        s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// result_index, cash, reserved_cash, shares, cost_basis,
	// reserved_shares, realized_pnl, change_count, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// status
	output logic [ST_W-1:0]        m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LIMIT_W-1:0]     cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	localparam int PAD_W = OUT_TDATA_W - IDX_W - REC_W;

	function automatic logic [KEY_W-1:0] key_norm(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] r;
		logic             stop;
		r    = '0;
		stop = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (k[8*i +: 8] == 8'd0) stop = 1'b1;
			if (!stop) r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction

	logic [2:0]              state_q;
	logic [LIMIT_W-1:0]      limit_q;
	logic [MAX_ACCOUNTS-1:0] in_use_q;
	logic [OP_W-1:0]         op_q;
	logic [KEY_W-1:0]        key_q;
	logic [IDX_W-1:0]        idx_q;
	logic [AMT_W-1:0]        amt_q;
	logic [AMT_W-1:0]        price_q;
	logic [PNL_W-1:0]        seed_q;
	logic [ST_W-1:0]         status_q;
	logic [CNT_W-1:0]        ptr_q;
	logic                    pend_s1;
	logic [IDX_W-1:0]        addr_s1;
	logic                    free_vld_q;
	logic [IDX_W-1:0]        free_q;
	logic [PROD_W-1:0]       prod_q;
	logic [VAL_W-1:0]        out_cost_q;
	alp_rec_t                rec_q;
	alp_rec_t                res_q;
	logic                    m_tvalid_q;
	logic [ST_W-1:0]         m_status_q;
	logic [IDX_W-1:0]        m_idx_q;
	alp_rec_t                m_rec_q;

	logic [CNT_W-1:0] n_w;
	logic             idx_ok;
	logic             in_use_w;
	logic [KEY_W-1:0] key_in_norm;
	logic             s_acc;
	logic             out_load;

	logic             key_re, key_we, hit_w, alloc_w, scan_end;
	logic [KEY_W-1:0] key_rdata;
	logic             rec_re, rec_we;
	logic [IDX_W-1:0] rec_waddr;
	alp_rec_t         rec_wdata, rec_rdata;

	logic             div_start, div_done;
	logic [VAL_W-1:0] div_quot;

	logic [ST_W-1:0]  ex_st;
	logic             ex_commit, ex_div, ex_fin, ex_whole;
	alp_rec_t         ex_rec;
	logic [ST_W-1:0]  fn_st;
	logic             fn_commit;
	alp_rec_t         fn_rec;

	// Slot count and index checks
	always_comb begin
		n_w      = (limit_q > LIMIT_W'(MAX_ACCOUNTS)) ? CNT_W'(MAX_ACCOUNTS) : CNT_W'(limit_q);
		idx_ok   = {1'b0, idx_q} < n_w;
		in_use_w = in_use_q[idx_q];
		s_acc    = s_tvalid && s_tready;
		key_in_norm = key_norm(s_tdata[KEY_W-1:0]);
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	// Key scan control
	always_comb begin
		hit_w    = (state_q == S_SCAN) && pend_s1 && in_use_q[addr_s1] && (key_rdata == key_q);
		scan_end = (state_q == S_SCAN) && !hit_w && !pend_s1 && (ptr_q >= n_w);
		key_re   = (state_q == S_SCAN) && (ptr_q < n_w) && !hit_w;
		alloc_w  = scan_end && free_vld_q;
		key_we   = alloc_w;
	end

	alp_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ACCOUNTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (free_q),
		.wdata (key_q),
		.re    (key_re),
		.raddr (ptr_q[IDX_W-1:0]),
		.rdata (key_rdata)
	);

	// Execute step: checks and new values
	always_comb begin
		logic [63:0] c64, r64, q64, k64, rs64, a64, p64;
		logic [63:0] nc, nr, nq, nk;
		c64  = {1'b0, rec_q.cash};
		r64  = {1'b0, rec_q.rcash};
		q64  = {1'b0, rec_q.shares};
		k64  = {1'b0, rec_q.cost};
		rs64 = {1'b0, rec_q.rshares};
		a64  = {{(64-AMT_W){1'b0}}, amt_q};
		p64  = {{(64-PROD_W){1'b0}}, prod_q};
		nc = c64; nr = r64; nq = q64; nk = k64;
		ex_rec    = rec_q;
		ex_rec.version = rec_q.version + 1'b1;
		ex_st     = ST_OK;
		ex_commit = 1'b0;
		ex_div    = 1'b0;
		ex_fin    = 1'b0;
		ex_whole  = (a64 == q64);
		if (op_q == OP_OPEN) begin
			ex_st = status_q;
		end else if (op_q >= OP_DEPOSIT && op_q <= OP_SETTLE) begin
			priority if (amt_q == '0) ex_st = ST_QTY;
			else if (!idx_ok)         ex_st = ST_INDEX;
			else if (!in_use_w)       ex_st = ST_NOTOPEN;
			else begin
				unique case (op_q)
					OP_DEPOSIT:  nc = c64 + a64;
					OP_WITHDRAW: begin
						if (a64 > c64) ex_st = ST_QTY;
						nc = c64 - a64;
					end
					OP_RESERVE:  nr = r64 + a64;
					OP_RELEASE:  begin
						if (a64 > r64) ex_st = ST_QTY;
						nr = r64 - a64;
					end
					default: begin
						if (a64 > c64 || a64 > r64) ex_st = ST_QTY;
						nc = c64 - a64;
						nr = r64 - a64;
					end
				endcase
				if (nc[63] || nr[63] || nr > nc) ex_st = ST_QTY;
				ex_rec.cash  = nc[VAL_W-1:0];
				ex_rec.rcash = nr[VAL_W-1:0];
				ex_commit    = (ex_st == ST_OK);
			end
		end else if (op_q >= OP_BUY && op_q <= OP_SEED) begin
			priority if ((op_q == OP_BUY || op_q == OP_SELL) && price_q == '0) ex_st = ST_PRICE;
			else if (!idx_ok)                           ex_st = ST_INDEX;
			else if (op_q != OP_SEED && amt_q == '0)    ex_st = ST_QTY;
			else if (!in_use_w)                         ex_st = ST_NOTOPEN;
			else begin
				nr = rs64;
				unique case (op_q)
					OP_BUY: begin
						nq = q64 + a64;
						nk = k64 + p64;
					end
					OP_SELL_RES: begin
						if (rs64 > q64 || a64 > q64 - rs64) ex_st = ST_QTY;
						nr = rs64 + a64;
					end
					OP_SELL_REL: begin
						if (a64 > rs64) ex_st = ST_QTY;
						nr = rs64 - a64;
					end
					OP_SELL: begin
						if (a64 > q64 || a64 > rs64) ex_st = ST_QTY;
					end
					default: begin
						nq = a64;
						nk = {{(64-AMT_W){1'b0}}, price_q};
						nr = '0;
						ex_rec.realized = seed_q;
					end
				endcase
				if (nq[63] || nk[63] || nr > nq) ex_st = ST_QTY;
				ex_rec.shares  = nq[VAL_W-1:0];
				ex_rec.cost    = nk[VAL_W-1:0];
				ex_rec.rshares = nr[VAL_W-1:0];
				if (op_q == OP_SELL) begin
					ex_div = (ex_st == ST_OK) && !ex_whole;
					ex_fin = (ex_st == ST_OK) && ex_whole;
				end else begin
					ex_commit = (ex_st == ST_OK);
				end
			end
		end else begin
			priority if (!idx_ok) ex_st = ST_INDEX;
			else if (!in_use_w)   ex_st = ST_NOTOPEN;
			else                  ex_st = ST_OK;
		end
	end

	// Sell fill finish: book realized P&L and take out the cost share
	always_comb begin
		logic [PNL_W-1:0] dlt;
		logic [PNL_W:0]   sum;
		dlt = {{(PNL_W-PROD_W){1'b0}}, prod_q} - {1'b0, out_cost_q};
		sum = {rec_q.realized[PNL_W-1], rec_q.realized} + {dlt[PNL_W-1], dlt};
		fn_rec          = rec_q;
		fn_rec.version  = rec_q.version + 1'b1;
		fn_rec.realized = sum[PNL_W-1:0];
		fn_rec.cost     = rec_q.cost - out_cost_q;
		fn_rec.shares   = rec_q.shares - VAL_W'(amt_q);
		fn_rec.rshares  = rec_q.rshares - VAL_W'(amt_q);
		fn_st           = (sum[PNL_W] != sum[PNL_W-1]) ? ST_QTY : ST_OK;
		fn_commit       = (fn_st == ST_OK);
	end

	assign div_start = (state_q == S_EXEC) && ex_div;

	alp_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (rec_q.cost),
		.m      (amt_q),
		.d      (rec_q.shares),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Record RAM access
	always_comb begin
		rec_re    = (state_q == S_RD);
		rec_we    = alloc_w || ((state_q == S_EXEC) && ex_commit) ||
		            ((state_q == S_FIN) && fn_commit);
		rec_waddr = alloc_w ? free_q : idx_q;
		if (alloc_w)                rec_wdata = '0;
		else if (state_q == S_FIN)  rec_wdata = fn_rec;
		else                        rec_wdata = ex_rec;
	end

	alp_ram #(.WIDTH(REC_W), .DEPTH(MAX_ACCOUNTS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (idx_q),
		.rdata (rec_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			limit_q    <= LIMIT_W'(MAX_ACCOUNTS);
			in_use_q   <= '0;
			pend_s1    <= 1'b0;
			free_vld_q <= 1'b0;
			ptr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			// load the output beat, or drop it once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						op_q       <= s_tuser;
						key_q      <= key_in_norm;
						idx_q      <= s_tdata[71:64];
						amt_q      <= s_tdata[102:72];
						price_q    <= s_tdata[133:103];
						seed_q     <= s_tdata[197:134];
						ptr_q      <= '0;
						pend_s1    <= 1'b0;
						free_vld_q <= 1'b0;
						status_q   <= (s_tuser == OP_OPEN && key_in_norm == '0) ?
						              ST_EMPTY : ST_OK;
						if (s_tuser == OP_OPEN && key_in_norm != '0) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= key_re;
					addr_s1 <= ptr_q[IDX_W-1:0];
					if (key_re) begin
						ptr_q <= ptr_q + 1'b1;
					end
					// remember the lowest free slot
					if (pend_s1 && !in_use_q[addr_s1] && !free_vld_q) begin
						free_vld_q <= 1'b1;
						free_q     <= addr_s1;
					end
					if (hit_w) begin
						idx_q    <= addr_s1;
						status_q <= ST_OK;
						state_q  <= S_RD;
					end else if (scan_end) begin
						if (free_vld_q) begin
							idx_q            <= free_q;
							in_use_q[free_q] <= 1'b1;
							status_q         <= ST_OK;
						end else begin
							status_q <= ST_FULL;
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					prod_q  <= amt_q * price_q;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					rec_q   <= in_use_w ? rec_rdata : '0;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					status_q <= ex_st;
					res_q    <= ex_commit ? ex_rec : rec_q;
					if (ex_div) begin
						state_q <= S_DIV;
					end else if (ex_fin) begin
						out_cost_q <= rec_q.cost;
						state_q    <= S_FIN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						out_cost_q <= div_quot;
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					status_q <= fn_st;
					res_q    <= fn_commit ? fn_rec : rec_q;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						m_status_q <= status_q;
						m_idx_q    <= idx_q;
						m_rec_q    <= idx_ok ? res_q : '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_rec_q, m_idx_q};

endmodule

[hdl/alp_checker.sv]
// Port-level checker for the account ledger, bound to the top level.
module alp_checker
	import alp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [ST_W-1:0]        m_tuser
);

	localparam int VAL_LO = IDX_W;
	localparam int VAL_HI = IDX_W + REC_W - 1;

	// One item at a time: no beat straight after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken twice in a row");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// Bad index gives all-zero values
	a_bad_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_INDEX) |-> (m_tdata[VAL_HI:VAL_LO] == '0))
		else $error("bad index with non-zero values");

	// A slot never opened reads as zero
	a_not_open_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_NOTOPEN) |-> (m_tdata[VAL_HI:VAL_LO] == '0))
		else $error("unopened slot with non-zero values");

endmodule

bind account_balance_position_ledger alp_checker u_alp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the account ledger: predictor, stream driver and result monitor.
module testbench
	import alp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_QUERY = 4'd11;
	localparam bit [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam bit [30:0] AMT_MAX = 31'h7FFF_FFFF;

	typedef struct {
		logic [OP_W-1:0]       op;
		logic [IN_TDATA_W-1:0] data;
	} ledger_req_t;

	typedef struct {
		bit [ST_W-1:0] status;
		bit [7:0]      index;
		bit [63:0]     cash, rcash, shares, cost, rshares, pnl;
		bit [31:0]     version;
	} ledger_res_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]        s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [ST_W-1:0]        m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [LIMIT_W-1:0]     cfg_data = '0;

	// Shadow copy of the account table and the slot limit
	bit [63:0] acct_key[MAX_ACCOUNTS];
	bit        acct_used[MAX_ACCOUNTS];
	bit [63:0] acct_cash[MAX_ACCOUNTS], acct_rcash[MAX_ACCOUNTS];
	bit [63:0] acct_shares[MAX_ACCOUNTS], acct_cost[MAX_ACCOUNTS];
	bit [63:0] acct_rshares[MAX_ACCOUNTS], acct_pnl[MAX_ACCOUNTS];
	bit [31:0] acct_ver[MAX_ACCOUNTS];
	int        slot_limit = 256;

	ledger_req_t ledger_pending[$];
	ledger_res_t ledger_expect[$];
	bit [63:0]   key_pool[$];
	int          errors = 0;

	account_balance_position_ledger u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	function automatic int slots();
		return (slot_limit > MAX_ACCOUNTS) ? MAX_ACCOUNTS : slot_limit;
	endfunction

	// Work out status and post-operation account values for one request
	function automatic ledger_res_t ledger_apply(logic [OP_W-1:0] op, bit [63:0] key,
			bit [7:0] idx_in, bit [30:0] amt, bit [30:0] price, bit [63:0] seed);
		ledger_res_t res;
		int        idx, n, i;
		bit [63:0] k, c, r, nc, nr, q, cs, rs, nq, ncs, nrs, nz, outc, proc, qty, d;
		bit [127:0] prod;
		logic [64:0] sum;
		bit [ST_W-1:0] st;
		bit        stop;
		idx = idx_in;
		n = slots();
		st = ST_OK;
		qty = {33'd0, amt};
		if (op == OP_OPEN) begin
			k = '0;
			stop = 1'b0;
			for (i = 0; i < KEY_BYTES; i++) begin
				if (key[8*i +: 8] == 8'd0) stop = 1'b1;
				if (!stop) k[8*i +: 8] = key[8*i +: 8];
			end
			if (k == 0) st = ST_EMPTY;
			else begin
				stop = 1'b0;
				for (i = 0; i < n && !stop; i++)
					if (acct_used[i] && acct_key[i] == k) begin
						idx = i;
						stop = 1'b1;
					end
				for (i = 0; i < n && !stop; i++)
					if (!acct_used[i]) begin
						acct_key[i] = k; acct_used[i] = 1'b1;
						acct_cash[i] = 0; acct_rcash[i] = 0; acct_shares[i] = 0;
						acct_cost[i] = 0; acct_rshares[i] = 0; acct_pnl[i] = 0;
						acct_ver[i] = 0;
						idx = i;
						stop = 1'b1;
					end
				if (!stop) st = ST_FULL;
			end
		end else if (op >= OP_DEPOSIT && op <= OP_SETTLE) begin
			if (amt == 0) st = ST_QTY;
			else if (idx >= n) st = ST_INDEX;
			else if (!acct_used[idx]) st = ST_NOTOPEN;
			else begin
				c = acct_cash[idx]; r = acct_rcash[idx]; nc = c; nr = r;
				case (op)
					OP_DEPOSIT: nc = c + qty;
					OP_WITHDRAW: if (qty > c) st = ST_QTY; else nc = c - qty;
					OP_RESERVE: nr = r + qty;
					OP_RELEASE: if (qty > r) st = ST_QTY; else nr = r - qty;
					default: begin
						if (qty > c || qty > r) st = ST_QTY;
						else begin
							nc = c - qty; nr = r - qty;
						end
					end
				endcase
				if (st == ST_OK && (nc > MAX63 || nr > MAX63 || nr > nc)) st = ST_QTY;
				if (st == ST_OK) begin
					acct_cash[idx] = nc; acct_rcash[idx] = nr; acct_ver[idx]++;
				end
			end
		end else if (op >= OP_BUY && op <= OP_SEED) begin
			if ((op == OP_BUY || op == OP_SELL) && price == 0) st = ST_PRICE;
			else if (idx >= n) st = ST_INDEX;
			else if (op != OP_SEED && amt == 0) st = ST_QTY;
			else if (!acct_used[idx]) st = ST_NOTOPEN;
			else begin
				q = acct_shares[idx]; cs = acct_cost[idx]; rs = acct_rshares[idx];
				nq = q; ncs = cs; nrs = rs; nz = acct_pnl[idx];
				proc = {33'd0, price} * qty;
				case (op)
					OP_BUY: begin
						nq = q + qty; ncs = cs + proc;
					end
					OP_SELL_RES: if (rs > q || qty > q - rs) st = ST_QTY; else nrs = rs + qty;
					OP_SELL_REL: if (qty > rs) st = ST_QTY; else nrs = rs - qty;
					OP_SELL: begin
						if (qty > q || qty > rs) st = ST_QTY;
						else begin
							prod = {64'd0, cs} * {64'd0, qty};
							outc = (qty == q) ? cs : 64'(prod / {64'd0, q});
							d = proc - outc;
							sum = {nz[63], nz} + {d[63], d};
							if (sum[64] != sum[63]) st = ST_QTY;
							else begin
								nz = sum[63:0]; ncs = cs - outc; nq = q - qty; nrs = rs - qty;
							end
						end
					end
					default: begin
						nq = qty; ncs = {33'd0, price}; nrs = 0; nz = seed;
					end
				endcase
				if (st == ST_OK && (nq > MAX63 || ncs > MAX63 || nrs > nq)) st = ST_QTY;
				if (st == ST_OK) begin
					acct_shares[idx] = nq; acct_cost[idx] = ncs; acct_rshares[idx] = nrs;
					acct_pnl[idx] = nz; acct_ver[idx]++;
				end
			end
		end else begin
			if (idx >= n) st = ST_INDEX;
			else if (!acct_used[idx]) st = ST_NOTOPEN;
		end
		res.status = st;
		res.index = idx[7:0];
		if (idx < n) begin
			res.cash = acct_cash[idx]; res.rcash = acct_rcash[idx];
			res.shares = acct_shares[idx]; res.cost = acct_cost[idx];
			res.rshares = acct_rshares[idx]; res.pnl = acct_pnl[idx];
			res.version = acct_ver[idx];
		end else begin
			res.cash = 0; res.rcash = 0; res.shares = 0; res.cost = 0;
			res.rshares = 0; res.pnl = 0; res.version = 0;
		end
		return res;
	endfunction

	// Queue one request and its predicted result
	task automatic issue(logic [OP_W-1:0] op, bit [63:0] key, bit [7:0] idx,
			bit [30:0] amt, bit [30:0] price, bit [63:0] seed);
		ledger_req_t req;
		req.op = op;
		req.data = {2'b00, seed, price, amt, idx, key};
		ledger_expect.push_back(ledger_apply(op, key, idx, amt, price, seed));
		ledger_pending.push_back(req);
	endtask

	function automatic bit [30:0] wide_amt();
		return 31'($urandom & {1'b0, AMT_MAX});
	endfunction

	// Random quantity from 1 up to the given headroom, clipped to the field
	function automatic bit [30:0] fit_amt(bit [63:0] room);
		if (room == 0) return 31'd1;
		if (room > {33'd0, AMT_MAX}) room = {33'd0, AMT_MAX};
		return 31'($urandom_range(1, {1'b0, room[30:0]}));
	endfunction

	function automatic bit [63:0] rand_key();
		bit [63:0] k;
		k = {$urandom, $urandom};
		if ($urandom_range(0, 4) == 0) k[8*$urandom_range(0, 7) +: 8] = 8'd0;
		return k;
	endfunction

	// Mostly well-formed traffic on open accounts, some opens and some noise
	task automatic random_items(int count);
		int        i, pick, sel, open_list[$];
		bit [7:0]  idx;
		bit [30:0] amt, price;
		bit [63:0] key;
		logic [OP_W-1:0] op;
		for (i = 0; i < count; i++) begin
			open_list.delete();
			for (int s = 0; s < slots(); s++) if (acct_used[s]) open_list.push_back(s);
			pick = $urandom_range(0, 99);
			if (pick < 8 || open_list.size() == 0) begin
				if (key_pool.size() > 0 && $urandom_range(0, 1) == 0)
					key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				else begin
					key = rand_key();
					key_pool.push_back(key);
				end
				issue(OP_OPEN, key, 8'($urandom), 0, 0, 0);
			end else if (pick < 92) begin
				idx = 8'(open_list[$urandom_range(0, open_list.size() - 1)]);
				sel = $urandom_range(1, 11);
				op = OP_W'(sel);
				price = ($urandom_range(0, 2) == 0) ? wide_amt() : 31'($urandom_range(1, 5000));
				case (op)
					OP_DEPOSIT: amt = ($urandom_range(0, 3) == 0) ? wide_amt()
						: 31'($urandom_range(1, 100000));
					OP_WITHDRAW: amt = fit_amt(acct_cash[idx]);
					OP_RESERVE: amt = fit_amt(acct_cash[idx] - acct_rcash[idx]);
					OP_RELEASE, OP_SETTLE: amt = fit_amt(acct_rcash[idx]);
					OP_BUY: amt = ($urandom_range(0, 3) == 0) ? wide_amt()
						: 31'($urandom_range(1, 1000));
					OP_SELL_RES: amt = fit_amt(acct_shares[idx] - acct_rshares[idx]);
					OP_SELL_REL, OP_SELL: amt = fit_amt(acct_rshares[idx]);
					OP_SEED: amt = ($urandom_range(0, 4) == 0) ? 31'd0 : wide_amt();
					default: amt = wide_amt();
				endcase
				// break a tenth of them on purpose
				if ($urandom_range(0, 9) == 0) amt = wide_amt();
				issue(op, 64'($urandom), idx, amt, price, {$urandom, $urandom});
			end else begin
				op = OP_W'($urandom_range(0, 15));
				issue(op, rand_key(), 8'($urandom), wide_amt(), wide_amt(), {$urandom, $urandom});
			end
		end
	endtask

	// Let the block drain, then write the slot limit
	task automatic set_limit(int value);
		while (ledger_pending.size() != 0 || ledger_expect.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value[LIMIT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		slot_limit = value;
	endtask

	// Stimulus sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		set_limit(256);
		// opens: empty keys, first slot, match ignoring bytes after a zero, second slot
		issue(OP_OPEN, 64'd0, 0, 0, 0, 0);
		issue(OP_OPEN, 64'hFFFF_FFFF_FFFF_FF00, 0, 0, 0, 0);
		issue(OP_OPEN, 64'h0000_0000_0000_0041, 0, 0, 0, 0);
		issue(OP_OPEN, 64'hABCD_0000_0000_0041, 0, 0, 0, 0);
		issue(OP_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
		// cash path: zero amount, not open, overdraw, reserve, settle
		issue(OP_DEPOSIT, 0, 0, 0, 0, 0);
		issue(OP_DEPOSIT, 0, 8'd255, 31'd5, 0, 0);
		issue(OP_DEPOSIT, 0, 0, AMT_MAX, 0, 0);
		issue(OP_WITHDRAW, 0, 0, AMT_MAX, 0, 0);
		issue(OP_RESERVE, 0, 0, 31'd1000, 0, 0);
		issue(OP_RESERVE, 0, 0, AMT_MAX, 0, 0);
		issue(OP_RELEASE, 0, 0, 31'd400, 0, 0);
		issue(OP_SETTLE, 0, 0, 31'd600, 0, 0);
		issue(OP_WITHDRAW, 0, 0, 31'd10, 0, 0);
		// position path: zero price, big buys until cost overflows, sells
		issue(OP_BUY, 0, 0, 31'd10, 31'd0, 0);
		issue(OP_BUY, 0, 0, AMT_MAX, AMT_MAX, 0);
		issue(OP_BUY, 0, 0, AMT_MAX, AMT_MAX, 0);
		issue(OP_BUY, 0, 0, AMT_MAX, AMT_MAX, 0);
		issue(OP_SELL_RES, 0, 0, AMT_MAX, 0, 0);
		issue(OP_SELL, 0, 0, 31'd3, 31'd7, 0);
		issue(OP_SELL_REL, 0, 0, 31'd1000, 0, 0);
		// seed near the top of realized, then a profitable sell of the whole holding
		issue(OP_SEED, 0, 1, 31'd5, 31'd10, 64'h7FFF_FFFF_FFFF_FFF0);
		issue(OP_SELL_RES, 0, 1, 31'd5, 0, 0);
		issue(OP_SELL, 0, 1, 31'd5, 31'd100, 0);
		issue(4'd13, 0, 1, 0, 0, 0);
		random_items(250);
		// single slot: full table and bad index
		set_limit(1);
		issue(OP_OPEN, 64'h0000_0000_0000_7A7A, 0, 0, 0, 0);
		issue(OP_DEPOSIT, 0, 1, 31'd5, 0, 0);
		random_items(60);
		set_limit(5);
		random_items(150);
		set_limit(256);
		random_items(160);
		while (ledger_pending.size() != 0 || ledger_expect.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	// Sender: bursts of beats with random gaps, valid held until taken
	int burst_left = 4;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (s_tvalid && s_tready) ledger_pending.delete(0);
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (ledger_pending.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= ledger_pending[0].data;
				s_tuser <= ledger_pending[0].op;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, bit [63:0] want, bit [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $realtime, name, want, got);
			errors++;
		end
	endtask

	// Receiver: compare each beat with the oldest expectation, stall on a pattern
	int unsigned cyc = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit held = 1'b0;
	ledger_res_t want;
	always @(posedge clk) begin
		cyc++;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (ledger_expect.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $realtime, m_tdata);
				errors++;
			end else begin
				want = ledger_expect.pop_front();
				check_field("status", 64'(want.status), 64'(m_tuser));
				check_field("result_index", 64'(want.index), 64'(m_tdata[7:0]));
				check_field("cash", want.cash, 64'(m_tdata[70:8]));
				check_field("reserved_cash", want.rcash, 64'(m_tdata[133:71]));
				check_field("shares", want.shares, 64'(m_tdata[196:134]));
				check_field("cost_basis", want.cost, 64'(m_tdata[259:197]));
				check_field("reserved_shares", want.rshares, 64'(m_tdata[322:260]));
				check_field("realized_pnl", want.pnl, m_tdata[386:323]);
				check_field("change_count", 64'(want.version), 64'(m_tdata[418:387]));
			end
		end
		// one long hold-off partway through to back up the input
		if (results_seen == 120 && !held) begin
			held = 1'b1;
			hold_left = 600;
		end
		if (hold_left > 0) hold_left--;
		m_tready <= arst_n && hold_left == 0 && (cyc[9] || $urandom_range(0, 2) != 0);
	end

endmodule
